FILE: design/sorted_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared property wrappers clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// sorted priority queue package
// sizes, command and status codes, request and response types
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int KEY_W       = 32;
   localparam int PAYLOAD_W   = 16;
   localparam int OCC_W       = 4;
   localparam logic signed [KEY_W-1:0] MAX_KEY_RESET = 32'sd10;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_PEEK   = 2'd1,
      CMD_POP    = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_KEY   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_PUT,
      ST_HEAD,
      ST_POP_SHIFT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      cmd_type                cmd;
      logic signed [KEY_W-1:0] key;
      logic [PAYLOAD_W-1:0]   payload;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic signed [KEY_W-1:0] head_key;
      logic [PAYLOAD_W-1:0]   head_payload;
      logic [OCC_W-1:0]       occupancy;
   } rsp_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [PAYLOAD_W-1:0]   payload;
   } entry_type;

endpackage

FILE: design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted priority queue
// Bounded queue of (key, payload) entries held in ascending key order in one
// synchronous memory. Requests: insert, peek head, pop head, clear; each
// request gives exactly one response with status, head entry and occupancy.
// Request channel: req_valid / req_stall / req_data, taken only while idle.
// Response channel: rsp_valid / rsp_stall / rsp_data from an output register;
// the next request is taken while an earlier response still waits there.
// Flow: a rejected insert, an empty peek or pop, and clear go straight to the
// finish state; a peek reads the head; an insert moves each entry with a key
// not below the new key one place toward the tail, then writes the new entry;
// a pop moves the count - 1 later entries one place toward the head, one at
// a time (one memory read and write per cycle). The user must write Max_key
// through csr_wr_en / csr_wr_data while idle; the block does not enforce it.
// Reset empties the queue, sets max_key to 10 and drops any pending
// response; memory contents are not cleared and need no clearing pass.
// A stalled response holds; a finished request then waits in its last state
// until the output register frees up.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  spq_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output spq_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic signed [spq_pkg::KEY_W-1:0]   csr_wr_data
);
   import spq_pkg::*;

   entry_type mem [QUEUE_DEPTH];

   state_type               state_ff, state_in;
   req_type                 cur_ff, cur_in;
   logic [ADDR_W-1:0]       count_ff, count_in;
   logic [ADDR_W-1:0]       idx_ff, idx_in;
   rsp_type                 res_ff, res_in;
   rsp_type                 rsp_data_ff;
   logic                    rsp_valid_ff;
   logic signed [KEY_W-1:0] max_key_ff;
   entry_type               rd_data_ff;

   logic                    rd_en, wr_en;
   logic [ADDR_W-1:0]       rd_addr, wr_addr;
   entry_type               wr_data;
   logic                    accept;
   logic                    out_free;
   logic                    is_full;
   logic                    key_bad;
   logic                    shift_up;
   entry_type               new_entry;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_full   = (count_ff == ADDR_W'(QUEUE_DEPTH - 1));
   assign key_bad   = ($signed(req_data.key) > max_key_ff);
   assign shift_up  = ($signed(rd_data_ff.key) >= $signed(cur_ff.key));
   assign new_entry = '{key: cur_ff.key, payload: cur_ff.payload};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_INSERT: begin
                     if (key_bad || is_full) begin
                        state_in = ST_FINISH;
                     end else if (count_ff == '0) begin
                        state_in = ST_INS_PUT;
                     end else begin
                        state_in = ST_INS_SCAN;
                     end
                  end
                  CMD_PEEK, CMD_POP: begin
                     state_in = (count_ff == '0) ? ST_FINISH : ST_HEAD;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_INS_SCAN: begin
            if (!shift_up) begin
               state_in = ST_FINISH;
            end else if (idx_ff == ADDR_W'(1)) begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: state_in = ST_FINISH;
         ST_HEAD: begin
            if (cur_ff.cmd == CMD_PEEK || count_ff == ADDR_W'(1)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_POP_SHIFT;
            end
         end
         ST_POP_SHIFT: begin
            if (idx_ff == count_ff - ADDR_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = new_entry;
      cur_in   = cur_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      res_in   = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in       = req_data;
               res_in       = '0;
               res_in.status = STATUS_OK;
               case (req_data.cmd)
                  CMD_INSERT: begin
                     if (key_bad) begin
                        res_in.status = STATUS_KEY;
                     end else if (is_full) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        idx_in = count_ff;
                        if (count_ff != '0) begin
                           rd_en   = 1'b1;
                           rd_addr = count_ff - ADDR_W'(1);
                        end
                     end
                  end
                  CMD_PEEK, CMD_POP: begin
                     if (count_ff == '0) begin
                        res_in.status = STATUS_EMPTY;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                     end
                  end
                  default: count_in = '0;
               endcase
            end
         end
         ST_INS_SCAN: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if (shift_up) begin
               wr_data = rd_data_ff;
               idx_in  = idx_ff - ADDR_W'(1);
               if (idx_ff != ADDR_W'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - ADDR_W'(2);
               end
            end else begin
               count_in = count_ff + ADDR_W'(1);
            end
         end
         ST_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            count_in = count_ff + ADDR_W'(1);
         end
         ST_HEAD: begin
            res_in.head_key     = rd_data_ff.key;
            res_in.head_payload = rd_data_ff.payload;
            if (cur_ff.cmd == CMD_POP) begin
               if (count_ff == ADDR_W'(1)) begin
                  count_in = '0;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ADDR_W'(1);
                  idx_in  = ADDR_W'(1);
               end
            end
         end
         ST_POP_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff - ADDR_W'(1);
            wr_data = rd_data_ff;
            if (idx_ff == count_ff - ADDR_W'(1)) begin
               count_in = count_ff - ADDR_W'(1);
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + ADDR_W'(1);
               idx_in  = idx_ff + ADDR_W'(1);
            end
         end
         ST_FINISH: begin
            res_in.occupancy = OCC_W'(count_ff);
         end
         default: ;
      endcase
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_data_ff <= res_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         max_key_ff   <= MAX_KEY_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            max_key_ff <= csr_wr_data;
         end
      end
   end

   `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= ADDR_W'(QUEUE_DEPTH - 1),
      "entry count above capacity")
   `SPQ_ASSERT_NOW(a_mem_no_overlap, wr_en && rd_en, wr_addr != rd_addr,
      "memory read and write to the same entry")
   `SPQ_ASSERT_NEXT(a_rsp_from_finish, state_ff == ST_FINISH && out_free,
      rsp_valid_ff && state_ff == ST_IDLE, "finished request not delivered")
   `SPQ_ASSERT_NOW(a_scan_index, state_ff == ST_INS_SCAN, idx_ff != '0,
      "insert scan below the head")
   `SPQ_ASSERT_NOW(a_shift_index, state_ff == ST_POP_SHIFT,
      idx_ff < count_ff && idx_ff != '0, "pop shift index out of range")

endmodule
